/* design/lmd_pkg.sv */
// Package with the constants, payload types and helper functions of the 3x3 local maximum detector.
package lmd_pkg;

	localparam int MAX_COLUMNS = 32;
	localparam int MAX_ROWS = 32;
	localparam int VALUE_BITS = 16;

	localparam int VALUE_FIELD_BITS = 16;
	localparam int ROW_INDEX_BITS = 5;
	localparam int COLUMN_INDEX_BITS = 5;
	localparam int COUNT_BITS = 11;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 6;

	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLUMNS + 1);
	localparam int STORE_DEPTH = 3 * MAX_COLUMNS;
	localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic KIND_DECISION = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = CFG_INDEX_BITS'(1);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [1:0] slot_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [STORE_ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic opcode;
		logic signed [VALUE_FIELD_BITS-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [ROW_INDEX_BITS-1:0] row_index;
		logic [COLUMN_INDEX_BITS-1:0] column_index;
		logic signed [VALUE_FIELD_BITS-1:0] decided_value;
		logic is_maximum;
		logic [COUNT_BITS-1:0] maximum_count;
		logic last;
	} result_t;

	function automatic slot_t slot_prev(input slot_t s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	function automatic slot_t slot_next(input slot_t s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic addr_t store_addr(input slot_t s, input col_t c);
		return addr_t'(s) * addr_t'(MAX_COLUMNS) + addr_t'(c);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] n,
			input logic inc);
		return (n == COUNT_LIMIT) ? n : n + COUNT_BITS'(inc);
	endfunction

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

endpackage

/* design/local_maximum_3x3_detector.sv */
// Top level of the 3x3 local maximum detector over a raster-ordered matrix stream.
//
// The block takes one word per cycle on the item channel: elements of the matrix in raster
// order, then one drain word per column of the last row. Each element is decided as soon as
// its right and lower neighbors are known; a word yields at most two result words (at the
// end of a row, and on the last drain word, which also carries the final count). Result
// words leave one per cycle while result_ready is high, through an eight-entry output
// queue, and item_ready drops when that queue lacks room for what is still in flight. The
// cycle after the last element is accepted, item_ready is low once while the first column
// of the last two rows is loaded for draining. Stage 1 reads the RAM and stage 2 compares
// the window before results are queued. The two previous rows live in a RAM of three rows
// by MAX_COLUMNS entries with one write and two reads per cycle; it needs no clearing after
// reset. Configuration is taken only before the first element and is ignored after it.
module local_maximum_3x3_detector (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       item_valid,
	output logic                                       item_ready,
	input  lmd_pkg::item_t                             item,
	output logic                                       result_valid,
	input  logic                                       result_ready,
	output lmd_pkg::result_t                           result,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [lmd_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
	input  logic [lmd_pkg::CFG_DATA_BITS-1:0]          cfg_data
);

	// Configuration and sequencing state.
	lmd_pkg::row_t rows_q;
	lmd_pkg::col_t cols_q;
	lmd_pkg::row_t row_q;
	lmd_pkg::col_t col_q;
	lmd_pkg::col_t drain_q;
	lmd_pkg::slot_t slot_q;
	logic started_q;
	logic full_q;
	logic finished_q;
	logic prefetch_q;
	logic [lmd_pkg::COUNT_BITS-1:0] found_q;

	lmd_pkg::row_t cfg_rows;
	lmd_pkg::col_t cfg_cols;

	// Step issued this cycle.
	logic accept;
	logic do_push;
	logic do_drain;
	logic step_v;
	logic step_dec_a;
	logic step_dec_b;
	logic step_fin;
	lmd_pkg::col_t step_col;
	lmd_pkg::col_t rd_col;
	lmd_pkg::value_t push_value;
	lmd_pkg::value_t rd_up1;
	lmd_pkg::value_t rd_up2;

	// Pipeline stages.
	logic v_s1;
	logic dec_a_s1;
	logic dec_b_s1;
	logic fin_s1;
	lmd_pkg::row_t row_s1;
	lmd_pkg::col_t col_s1;
	lmd_pkg::value_t value_s1;

	logic v_s2;
	logic dec_a_s2;
	logic dec_b_s2;
	logic fin_s2;
	lmd_pkg::row_t row_s2;
	lmd_pkg::col_t col_s2;

	lmd_pkg::value_t win_q [3][3];

	// Decision logic.
	logic top_ok;
	logic bot_ok;
	logic left_a;
	logic right_a;
	logic left_b;
	logic max_a;
	logic max_b;
	logic [lmd_pkg::COUNT_BITS-1:0] count_a;
	logic [lmd_pkg::COUNT_BITS-1:0] count_b;
	lmd_pkg::result_t res_a;
	lmd_pkg::result_t res_b;
	lmd_pkg::result_t res_f;
	lmd_pkg::result_t first_res;
	lmd_pkg::result_t second_res;
	logic push_first;
	logic push_second;

	// Output queue.
	lmd_pkg::result_t fifo_q [lmd_pkg::FIFO_DEPTH];
	logic [lmd_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [lmd_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [lmd_pkg::FIFO_CNT_W-1:0] fifo_cnt_q;
	logic [lmd_pkg::FIFO_CNT_W+1:0] credit;
	logic pop;
	logic [1:0] push_n;

	// Configuration.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_rows = lmd_pkg::ROW_W'(1);
		end else if (32'(cfg_data) > 32'(lmd_pkg::MAX_ROWS)) begin
			cfg_rows = lmd_pkg::ROW_W'(lmd_pkg::MAX_ROWS);
		end else begin
			cfg_rows = lmd_pkg::ROW_W'(cfg_data);
		end
		if (cfg_data == '0) begin
			cfg_cols = lmd_pkg::COL_W'(1);
		end else if (32'(cfg_data) > 32'(lmd_pkg::MAX_COLUMNS)) begin
			cfg_cols = lmd_pkg::COL_W'(lmd_pkg::MAX_COLUMNS);
		end else begin
			cfg_cols = lmd_pkg::COL_W'(cfg_data);
		end
	end

	assign cfg_ready = 1'b1;

	// Input side and step generation.
	assign credit = (lmd_pkg::FIFO_CNT_W + 2)'(fifo_cnt_q)
		+ (v_s1 ? (lmd_pkg::FIFO_CNT_W + 2)'(2) : '0)
		+ (v_s2 ? (lmd_pkg::FIFO_CNT_W + 2)'(2) : '0);
	assign item_ready = !prefetch_q
		&& (credit <= (lmd_pkg::FIFO_CNT_W + 2)'(lmd_pkg::FIFO_DEPTH - 2));

	assign accept = item_valid && item_ready;
	assign do_push = accept && (item.opcode == lmd_pkg::OP_PUSH) && !full_q && !finished_q;
	assign do_drain = accept && (item.opcode == lmd_pkg::OP_DRAIN) && full_q && !finished_q;
	assign step_v = do_push || do_drain || prefetch_q;
	assign push_value = lmd_pkg::value_t'(item.element_value);

	always_comb begin
		step_dec_a = 1'b0;
		step_dec_b = 1'b0;
		step_fin = 1'b0;
		step_col = '0;
		if (do_push) begin
			step_col = col_q;
			step_dec_a = (row_q != '0) && (col_q != '0);
			step_dec_b = (row_q != '0) && (col_q == cols_q - lmd_pkg::COL_W'(1));
		end else if (do_drain) begin
			step_col = drain_q + lmd_pkg::COL_W'(1);
			step_dec_a = 1'b1;
			step_fin = (drain_q == cols_q - lmd_pkg::COL_W'(1));
		end
		rd_col = (step_col < cols_q) ? step_col : '0;
	end

	lmd_ram #(
		.WIDTH(lmd_pkg::VALUE_BITS),
		.DEPTH(lmd_pkg::STORE_DEPTH)
	) u_row_store (
		.clk      (clk),
		.wr_en    (do_push),
		.wr_addr  (lmd_pkg::store_addr(slot_q, col_q)),
		.wr_data  (push_value),
		.rd_addr_a(lmd_pkg::store_addr(lmd_pkg::slot_prev(slot_q), rd_col)),
		.rd_data_a(rd_up1),
		.rd_addr_b(lmd_pkg::store_addr(lmd_pkg::slot_prev(lmd_pkg::slot_prev(slot_q)), rd_col)),
		.rd_data_b(rd_up2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lmd_pkg::ROW_W'(1);
			cols_q <= lmd_pkg::COL_W'(1);
			row_q <= '0;
			col_q <= '0;
			drain_q <= '0;
			slot_q <= '0;
			started_q <= 1'b0;
			full_q <= 1'b0;
			finished_q <= 1'b0;
			prefetch_q <= 1'b0;
		end else begin
			if (cfg_valid && !started_q) begin
				if (cfg_index == lmd_pkg::REG_ROW_COUNT) begin
					rows_q <= cfg_rows;
				end else if (cfg_index == lmd_pkg::REG_COLUMN_COUNT) begin
					cols_q <= cfg_cols;
				end
			end
			prefetch_q <= 1'b0;
			if (do_push) begin
				started_q <= 1'b1;
				if (col_q + lmd_pkg::COL_W'(1) == cols_q) begin
					col_q <= '0;
					row_q <= row_q + lmd_pkg::ROW_W'(1);
					slot_q <= lmd_pkg::slot_next(slot_q);
					if (row_q + lmd_pkg::ROW_W'(1) == rows_q) begin
						full_q <= 1'b1;
						prefetch_q <= 1'b1;
					end
				end else begin
					col_q <= col_q + lmd_pkg::COL_W'(1);
				end
			end
			if (do_drain) begin
				drain_q <= drain_q + lmd_pkg::COL_W'(1);
				if (step_fin) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	// Stage 1 and 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			dec_a_s1 <= 1'b0;
			dec_b_s1 <= 1'b0;
			fin_s1 <= 1'b0;
			v_s2 <= 1'b0;
			dec_a_s2 <= 1'b0;
			dec_b_s2 <= 1'b0;
			fin_s2 <= 1'b0;
		end else begin
			v_s1 <= step_v;
			dec_a_s1 <= step_dec_a;
			dec_b_s1 <= step_dec_b;
			fin_s1 <= step_fin;
			v_s2 <= v_s1;
			dec_a_s2 <= dec_a_s1;
			dec_b_s2 <= dec_b_s1;
			fin_s2 <= fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q - lmd_pkg::ROW_W'(1);
		col_s1 <= step_col;
		value_s1 <= push_value;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		if (v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_up2;
			win_q[1][2] <= rd_up1;
			win_q[2][2] <= value_s1;
		end
	end

	// Window compare. Row 1 of the window is the center row; columns 1 and 2 are the centers
	// of the two possible decisions.
	always_comb begin
		top_ok = (row_s2 != '0);
		bot_ok = ((lmd_pkg::ROW_W + 1)'(row_s2) + (lmd_pkg::ROW_W + 1)'(1))
			< (lmd_pkg::ROW_W + 1)'(rows_q);
		left_a = (col_s2 >= lmd_pkg::COL_W'(2));
		right_a = (col_s2 < cols_q);
		left_b = (col_s2 != '0);

		max_a = !((top_ok && ((left_a && (win_q[0][0] > win_q[1][1]))
				|| (win_q[0][1] > win_q[1][1])
				|| (right_a && (win_q[0][2] > win_q[1][1]))))
			|| (left_a && (win_q[1][0] > win_q[1][1]))
			|| (right_a && (win_q[1][2] > win_q[1][1]))
			|| (bot_ok && ((left_a && (win_q[2][0] > win_q[1][1]))
				|| (win_q[2][1] > win_q[1][1])
				|| (right_a && (win_q[2][2] > win_q[1][1])))));

		max_b = !((top_ok && ((left_b && (win_q[0][1] > win_q[1][2]))
				|| (win_q[0][2] > win_q[1][2])))
			|| (left_b && (win_q[1][1] > win_q[1][2]))
			|| (bot_ok && ((left_b && (win_q[2][1] > win_q[1][2]))
				|| (win_q[2][2] > win_q[1][2]))));

		count_a = lmd_pkg::sat_inc(found_q, dec_a_s2 && max_a);
		count_b = lmd_pkg::sat_inc(count_a, dec_b_s2 && max_b);

		res_a.kind = lmd_pkg::KIND_DECISION;
		res_a.row_index = lmd_pkg::ROW_INDEX_BITS'(row_s2);
		res_a.column_index = lmd_pkg::COLUMN_INDEX_BITS'(col_s2 - lmd_pkg::COL_W'(1));
		res_a.decided_value = lmd_pkg::VALUE_FIELD_BITS'(win_q[1][1]);
		res_a.is_maximum = max_a;
		res_a.maximum_count = count_a;
		res_a.last = 1'b0;

		res_b.kind = lmd_pkg::KIND_DECISION;
		res_b.row_index = lmd_pkg::ROW_INDEX_BITS'(row_s2);
		res_b.column_index = lmd_pkg::COLUMN_INDEX_BITS'(col_s2);
		res_b.decided_value = lmd_pkg::VALUE_FIELD_BITS'(win_q[1][2]);
		res_b.is_maximum = max_b;
		res_b.maximum_count = count_b;
		res_b.last = 1'b0;

		res_f.kind = lmd_pkg::KIND_FINAL;
		res_f.row_index = '0;
		res_f.column_index = '0;
		res_f.decided_value = '0;
		res_f.is_maximum = 1'b0;
		res_f.maximum_count = count_a;
		res_f.last = 1'b1;

		push_first = dec_a_s2 || dec_b_s2;
		push_second = dec_a_s2 && (dec_b_s2 || fin_s2);
		first_res = dec_a_s2 ? res_a : res_b;
		second_res = fin_s2 ? res_f : res_b;
		push_n = 2'(push_first) + 2'(push_second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (v_s2) begin
			found_q <= count_b;
		end
	end

	// Output queue.
	assign pop = result_valid && result_ready;
	assign result_valid = (fifo_cnt_q != '0);
	assign result = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push_second) begin
				wr_ptr_q <= lmd_pkg::ptr_inc(lmd_pkg::ptr_inc(wr_ptr_q));
			end else if (push_first) begin
				wr_ptr_q <= lmd_pkg::ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= lmd_pkg::ptr_inc(rd_ptr_q);
			end
			fifo_cnt_q <= fifo_cnt_q + lmd_pkg::FIFO_CNT_W'(push_n)
				- lmd_pkg::FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_first) begin
			fifo_q[wr_ptr_q] <= first_res;
		end
		if (push_second) begin
			fifo_q[lmd_pkg::ptr_inc(wr_ptr_q)] <= second_res;
		end
	end

	// The credit check at the input must leave room for both results of a stage-2 word.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_first |-> fifo_cnt_q <= lmd_pkg::FIFO_CNT_W'(lmd_pkg::FIFO_DEPTH - 2))
		else $error("output queue lacks room for a word in stage 2");

	// Once the final count is out, nothing else may follow.
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.last |=> !result_valid)
		else $error("result word after the final count");

	// After the final drain word no step enters the pipeline.
	a_no_step_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$past(finished_q) |-> !step_v)
		else $error("step issued after the matrix was finished");

	// A second decision comes only at the last column of a row.
	a_second_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		dec_b_s1 |-> col_s1 == cols_q - lmd_pkg::COL_W'(1))
		else $error("second decision away from the row end");

endmodule

/* design/lmd_ram.sv */
// Generic RAM with one write port and two registered read ports.
module lmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

/* tb/sv/local_maximum_3x3_detector_tb.sv */
// Testbench for the 3x3 local maximum detector: predicts every decision and the final count.
`timescale 1ns / 100ps

module local_maximum_3x3_detector_tb;
	import lmd_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int ROW_SETTING = 63;
	localparam int COLUMN_SETTING = 32;
	localparam int ELEMENTS = MAX_ROWS * COLUMN_SETTING;
	localparam int PHASE_LENGTH = ELEMENTS / 4;
	localparam int HOLD_AT = 100;
	localparam int LONG_HOLD = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 20;
	localparam int TRAILING_ITEMS = 700;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEYOND_LIST_LOW = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEYOND_LIST_HIGH = CFG_INDEX_BITS'(3);
	localparam int SEND_IDLE_PCT[4] = '{0, 46, 0, 20};
	localparam int RECV_STALL_PCT[4] = '{0, 0, 46, 20};
	localparam int EDGE_COUNT = 20;
	localparam value_t EDGE_VALUES[EDGE_COUNT] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF,
		16'h8000, 16'h8000, 16'h0064, 16'h0064, 16'hFF9C, 16'h4000, 16'hC000, 16'h0000,
		16'h0000, 16'h7FFE, 16'h8001, 16'h0002
	};

	class maxima_scoreboard;
		value_t element_rows[STORE_DEPTH];
		logic [CFG_DATA_BITS-1:0] row_setting;
		logic [CFG_DATA_BITS-1:0] column_setting;
		int in_row;
		int in_column;
		int drain_column;
		logic [COUNT_BITS-1:0] maxima_found;
		bit matrix_full;
		bit finished;
		result_t expected_decisions[$];
		int errors;

		function new();
			foreach (element_rows[i]) element_rows[i] = '0;
			row_setting = 1;
			column_setting = 1;
			in_row = 0;
			in_column = 0;
			drain_column = 0;
			maxima_found = '0;
			matrix_full = 1'b0;
			finished = 1'b0;
			errors = 0;
		endfunction

		function int rows_in_use();
			if (row_setting == 0) return 1;
			if (row_setting > MAX_ROWS) return MAX_ROWS;
			return row_setting;
		endfunction

		function int columns_in_use();
			if (column_setting == 0) return 1;
			if (column_setting > MAX_COLUMNS) return MAX_COLUMNS;
			return column_setting;
		endfunction

		function value_t element_at(int r, int c);
			return element_rows[(r % 3) * MAX_COLUMNS + c];
		endfunction

		function void take_register(logic [CFG_INDEX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] data);
			if (in_row != 0 || in_column != 0 || matrix_full || finished) return;
			if (idx == REG_ROW_COUNT) row_setting = data;
			else if (idx == REG_COLUMN_COUNT) column_setting = data;
		endfunction

		function result_t decide_element(int r, int c);
			int rows = rows_in_use();
			int cols = columns_in_use();
			value_t center = element_at(r, c);
			logic peak = 1'b1;
			result_t d;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
							c + dc >= 0 && c + dc < cols &&
							element_at(r + dr, c + dc) > center)
						peak = 1'b0;
				end
			end
			if (peak && maxima_found != COUNT_LIMIT) maxima_found = maxima_found + 1'b1;
			d = '0;
			d.kind = KIND_DECISION;
			d.row_index = ROW_INDEX_BITS'(r);
			d.column_index = COLUMN_INDEX_BITS'(c);
			d.decided_value = center;
			d.is_maximum = peak;
			d.maximum_count = maxima_found;
			d.last = 1'b0;
			return d;
		endfunction

		function void take_item(item_t w);
			int rows = rows_in_use();
			int cols = columns_in_use();
			result_t total;
			if (finished) return;
			if (w.opcode == OP_PUSH) begin
				if (matrix_full) return;
				element_rows[(in_row % 3) * MAX_COLUMNS + in_column] = w.element_value;
				if (in_row >= 1) begin
					if (in_column >= 1)
						expected_decisions.push_back(decide_element(in_row - 1, in_column - 1));
					if (in_column == cols - 1)
						expected_decisions.push_back(decide_element(in_row - 1, in_column));
				end
				in_column++;
				if (in_column >= cols) begin
					in_column = 0;
					in_row++;
					if (in_row >= rows) begin
						in_row = 0;
						matrix_full = 1'b1;
					end
				end
				return;
			end
			if (!matrix_full) return;
			expected_decisions.push_back(decide_element(rows - 1, drain_column));
			drain_column++;
			if (drain_column >= cols) begin
				total = '0;
				total.kind = KIND_FINAL;
				total.maximum_count = maxima_found;
				total.last = 1'b1;
				expected_decisions.push_back(total);
				finished = 1'b1;
			end
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_decisions.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, expected none, got %p",
					$time, got);
				return;
			end
			want = expected_decisions.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("row_index", want.row_index, got.row_index);
			compare_field("column_index", want.column_index, got.column_index);
			compare_field("decided_value", want.decided_value, got.decided_value);
			compare_field("is_maximum", want.is_maximum, got.is_maximum);
			compare_field("maximum_count", want.maximum_count, got.maximum_count);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return expected_decisions.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	maxima_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	local_maximum_3x3_detector u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = holds_served + 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready) board.check_result(result);
		if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready) ||
				(cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic item_t make_item(input logic op, input value_t v);
		item_t w;
		w.opcode = op;
		w.element_value = v;
		return w;
	endfunction

	function automatic value_t random_element();
		int pick = $urandom_range(99);
		if (pick < 60) return value_t'(int'($urandom_range(6)) - 3);
		if (pick < 90) return value_t'($urandom());
		if (pick < 95) return 16'h7FFF;
		return 16'h8000;
	endfunction

	function automatic int idle_gap();
		int gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		return gap;
	endfunction

	task automatic send_item(input item_t w, input int gap);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_ready !== 1'b1);
		board.take_item(w);
	endtask

	task automatic release_item();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.take_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pause_until_drained();
		release_item();
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int n;
		value_t v;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_register(REG_ROW_COUNT, '0);
		write_register(REG_COLUMN_COUNT, '1);
		write_register(REG_BEYOND_LIST_LOW, '1);
		write_register(REG_BEYOND_LIST_HIGH, '0);
		write_register(REG_COLUMN_COUNT, CFG_DATA_BITS'(1));
		write_register(REG_ROW_COUNT, CFG_DATA_BITS'(ROW_SETTING));
		write_register(REG_COLUMN_COUNT, CFG_DATA_BITS'(COLUMN_SETTING));

		// A drain word ahead of any element must be dropped.
		send_item(make_item(OP_DRAIN, 16'hFFFF), 0);
		for (n = 0; n < ELEMENTS; n++) begin
			if (n > 0 && n % PHASE_LENGTH == 0) begin
				pause_until_drained();
				write_register(CFG_INDEX_BITS'($urandom_range(3)),
					CFG_DATA_BITS'($urandom_range(63)));
				send_idle_pct = SEND_IDLE_PCT[n / PHASE_LENGTH];
				recv_stall_pct = RECV_STALL_PCT[n / PHASE_LENGTH];
			end
			if (n == HOLD_AT) hold_requests++;
			if (n < EDGE_COUNT) begin
				v = EDGE_VALUES[n];
				if (n == EDGE_COUNT / 2) send_item(make_item(OP_DRAIN, 16'h7FFF), 0);
			end else begin
				if ($urandom_range(99) < 3)
					send_item(make_item(OP_DRAIN, random_element()), idle_gap());
				v = random_element();
			end
			send_item(make_item(OP_PUSH, v), idle_gap());
		end

		// Elements beyond the matrix are dropped.
		send_item(make_item(OP_PUSH, random_element()), idle_gap());
		send_item(make_item(OP_PUSH, random_element()), idle_gap());
		pause_until_drained();
		write_register(REG_ROW_COUNT, CFG_DATA_BITS'(1));
		for (n = 0; n < COLUMN_SETTING; n++)
			send_item(make_item(OP_DRAIN, random_element()), idle_gap());

		// Nothing after the final count may produce a word.
		for (n = 0; n < TRAILING_ITEMS; n++)
			send_item(make_item(($urandom_range(1) == 0) ? OP_PUSH : OP_DRAIN,
				random_element()), idle_gap());
		pause_until_drained();
		write_register(REG_COLUMN_COUNT, '1);
		repeat (END_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
design/lmd_pkg.sv
design/lmd_ram.sv
design/local_maximum_3x3_detector.sv
tb/sv/local_maximum_3x3_detector_tb.sv
